### hw/rtl/ami_pkg.sv
// ----------------------------------------------------------------------------
// ami_pkg
// shared widths, types and the cofactor index table for the affine inverse
// ----------------------------------------------------------------------------
`default_nettype none

package ami_pkg;

  localparam int MW      = 32;          // element width
  localparam int PW      = 64;          // element product
  localparam int NW      = 65;          // cofactor
  localparam int TW      = 97;          // element times cofactor
  localparam int DETW    = 98;          // determinant
  localparam int QB      = 33;          // quotient bits kept before saturation
  localparam int RW      = DETW + QB;   // divider remainder
  localparam int DIV_LAT = QB + 2;      // divider depth in registers, input to quotient
  localparam int ACCW    = 66;          // translation accumulator

  localparam logic REG_THR = 1'b0;      // singular_threshold register index

  typedef logic signed [MW-1:0] word_t;

  typedef struct packed {
    logic vld;
    logic neg;
  } div_ctl_t;

  // cofactor k = m[A]*m[B] - m[C]*m[D]
  localparam int CF_A [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int CF_B [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int CF_C [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int CF_D [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

endpackage

`default_nettype wire

### hw/rtl/ami_div.sv
// ----------------------------------------------------------------------------
// ami_div
// pipelined restoring divider, one quotient bit per stage, saturated to 32 bits
// ----------------------------------------------------------------------------
`default_nettype none

module ami_div (
  input  logic                   clk,
  input  logic                   rst,
  input  ami_pkg::div_ctl_t      in_ctl,
  input  logic [ami_pkg::RW-1:0] num,
  input  logic [ami_pkg::RW-1:0] den,
  output ami_pkg::word_t         quo,
  output logic                   quo_vld
);
  import ami_pkg::*;

  localparam logic [QB-1:0] HALF = QB'(1) << (MW - 1);

  logic [RW-1:0] rem [0:QB];
  logic [RW-1:0] dsr [0:QB];
  logic [QB-1:0] qb  [0:QB];
  logic          ovf [0:QB];
  logic          neg [0:QB];
  logic          vld [0:QB];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_ctl.vld;
    end
    rem[0] <= num;
    dsr[0] <= den;
    qb[0]  <= '0;
    ovf[0] <= num >= (den << QB);
    neg[0] <= in_ctl.neg;
  end

  for (genvar s = 1; s <= QB; s++) begin : g_stage
    localparam int B = QB - s;
    logic [RW-1:0] shd;
    logic          ge;
    assign shd = dsr[s-1] << B;
    assign ge  = rem[s-1] >= shd;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else begin
        vld[s] <= vld[s-1];
      end
      rem[s] <= ge ? (rem[s-1] - shd) : rem[s-1];
      dsr[s] <= dsr[s-1];
      qb[s]  <= qb[s-1] | (QB'(ge) << B);
      ovf[s] <= ovf[s-1];
      neg[s] <= neg[s-1];
    end
  end

  word_t sat;
  always_comb begin
    if (neg[QB]) begin
      if (ovf[QB] || qb[QB] > HALF) begin
        sat = word_t'(HALF[MW-1:0]);
      end else begin
        sat = -word_t'(qb[QB][MW-1:0]);
      end
    end else begin
      if (ovf[QB] || qb[QB] >= HALF) begin
        sat = word_t'(~HALF[MW-1:0]);
      end else begin
        sat = word_t'(qb[QB][MW-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quo_vld <= 1'b0;
    end else begin
      quo_vld <= vld[QB];
    end
    quo <= sat;
  end

endmodule

`default_nettype wire

### hw/rtl/affine_matrix_inverse.sv
// ----------------------------------------------------------------------------
// affine_matrix_inverse
// inverse of an affine 3x4 transform by cofactors, signed fixed point
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; busy then stays high
// while the pacing counter runs down, so transforms enter no faster than the
// four result rows leave the single result port. The four rows follow on
// consecutive cycles (rows 0 to 2 of the inverse, then the translation row
// with last_row). The rows come out of the cofactor front end, the issue
// buffer and the 33-stage divider; three divider lanes take one row per cycle.
// The receiver cannot stall, so every strobe is one result.
// ----------------------------------------------------------------------------
`default_nettype none

module affine_matrix_inverse #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  ami_pkg::word_t        m00,
  input  ami_pkg::word_t        m01,
  input  ami_pkg::word_t        m02,
  input  ami_pkg::word_t        m10,
  input  ami_pkg::word_t        m11,
  input  ami_pkg::word_t        m12,
  input  ami_pkg::word_t        m20,
  input  ami_pkg::word_t        m21,
  input  ami_pkg::word_t        m22,
  input  ami_pkg::word_t        tx,
  input  ami_pkg::word_t        ty,
  input  ami_pkg::word_t        tz,
  output logic                  strobe,
  output logic [1:0]            row_index,
  output ami_pkg::word_t        col0,
  output ami_pkg::word_t        col1,
  output ami_pkg::word_t        col2,
  output logic                  singular,
  output logic                  last_row,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import ami_pkg::*;

  typedef logic signed [PW-1:0]   prod_t;
  typedef logic signed [NW-1:0]   cof_t;
  typedef logic signed [NW-1:0]   part_t;
  typedef logic signed [TW-1:0]   term_t;
  typedef logic signed [DETW-1:0] det_t;
  typedef logic signed [ACCW-1:0] acc_t;

  typedef struct packed {
    logic [1:0] row;
    logic       sing;
    word_t      t;
  } tag_t;

  localparam word_t WMAX = word_t'({1'b0, {(MW-1){1'b1}}});
  localparam word_t WMIN = word_t'({1'b1, {(MW-1){1'b0}}});

  function automatic word_t tr_sat(acc_t a);
    logic signed [ACCW:0] ns;
    logic signed [ACCW:0] sh;
    ns = -(($bits(ns))'(a));
    sh = ns >>> FRAC_BITS;
    if (sh > ($bits(sh))'(WMAX)) begin
      return WMAX;
    end else if (sh < ($bits(sh))'(WMIN)) begin
      return WMIN;
    end
    return word_t'(sh[MW-1:0]);
  endfunction

  // configuration
  logic [15:0] thr;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= 16'd1;
    end else if (wr_en && paddr[2] == REG_THR) begin
      thr <= pwdata[15:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_THR) begin
      prdata = {16'd0, thr};
    end else begin
      prdata = '0;
    end
  end

  // input pacing
  logic [1:0] cnt;
  logic       acc_in;

  assign busy   = cnt != 2'd0;
  assign acc_in = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (acc_in) begin
      cnt <= 2'd3;
    end else if (busy) begin
      cnt <= cnt - 2'd1;
    end
  end

  // front end: cofactors and determinant
  word_t m_s0 [9];
  word_t t_s0 [3];
  logic  v0, v1, v2, v3, v4, v5, v6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= acc_in;
    end
    m_s0 <= '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
    t_s0 <= '{tx, ty, tz};
  end

  prod_t pa1 [9];
  prod_t pb1 [9];
  word_t mc1 [3];
  word_t t_s1 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
    for (int k = 0; k < 9; k++) begin
      pa1[k] <= m_s0[CF_A[k]] * m_s0[CF_B[k]];
      pb1[k] <= m_s0[CF_C[k]] * m_s0[CF_D[k]];
    end
    for (int k = 0; k < 3; k++) begin
      mc1[k] <= m_s0[3*k];
    end
    t_s1 <= t_s0;
  end

  cof_t  n2 [9];
  word_t mc2 [3];
  word_t t_s2 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    for (int k = 0; k < 9; k++) begin
      n2[k] <= cof_t'(pa1[k]) - cof_t'(pb1[k]);
    end
    mc2  <= mc1;
    t_s2 <= t_s1;
  end

  part_t lo3 [3];
  part_t hi3 [3];
  cof_t  n3 [9];
  word_t t_s3 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    for (int k = 0; k < 3; k++) begin
      lo3[k] <= mc2[k] * $signed({1'b0, n2[k][31:0]});
      hi3[k] <= mc2[k] * $signed(n2[k][NW-1:32]);
    end
    n3   <= n2;
    t_s3 <= t_s2;
  end

  term_t tm4 [3];
  cof_t  n4 [9];
  word_t t_s4 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    for (int k = 0; k < 3; k++) begin
      tm4[k] <= (term_t'(hi3[k]) <<< 32) + term_t'(lo3[k]);
    end
    n4   <= n3;
    t_s4 <= t_s3;
  end

  det_t  det5;
  cof_t  n5 [9];
  word_t t_s5 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    det5 <= det_t'(tm4[0]) + det_t'(tm4[1]) + det_t'(tm4[2]);
    n5   <= n4;
    t_s5 <= t_s4;
  end

  logic [DETW-1:0] dabs6;
  logic            dneg6;
  cof_t            n6 [9];
  word_t           t_s6 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= v5;
    end
    dabs6 <= det5[DETW-1] ? DETW'(-det5) : DETW'(det5);
    dneg6 <= det5[DETW-1];
    n6    <= n5;
    t_s6  <= t_s5;
  end

  // issue buffer, one row of three divisions per cycle
  logic [DETW-1:0] lim;
  logic [DETW-1:0] dab;
  logic            dng;
  logic            sing_b;
  cof_t            nb [9];
  word_t           tb [3];
  logic            ivld;
  logic [1:0]      irow;

  assign lim = DETW'(thr) << (2 * FRAC_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      ivld <= 1'b0;
      irow <= 2'd0;
    end else if (v6) begin
      ivld <= 1'b1;
      irow <= 2'd0;
    end else if (ivld) begin
      ivld <= irow != 2'd2;
      irow <= irow + 2'd1;
    end
    if (v6) begin
      dab    <= dabs6;
      dng    <= dneg6;
      sing_b <= lim >= dabs6;
      nb     <= n6;
      tb     <= t_s6;
    end
  end

  cof_t     nsel [3];
  word_t    tsel;
  div_ctl_t dctl [3];
  logic [RW-1:0] dnum [3];
  word_t    quo [3];
  logic     quo_vld [3];

  always_comb begin
    case (irow)
      2'd0: begin
        nsel = '{nb[0], nb[1], nb[2]};
        tsel = tb[0];
      end
      2'd1: begin
        nsel = '{nb[3], nb[4], nb[5]};
        tsel = tb[1];
      end
      default: begin
        nsel = '{nb[6], nb[7], nb[8]};
        tsel = tb[2];
      end
    endcase
  end

  for (genvar j = 0; j < 3; j++) begin : g_lane
    logic [NW-1:0] nmag;
    assign nmag     = nsel[j][NW-1] ? NW'(-nsel[j]) : NW'(nsel[j]);
    assign dnum[j]  = RW'(nmag) << (2 * FRAC_BITS);
    assign dctl[j]  = '{vld: ivld, neg: nsel[j][NW-1] ^ dng};

    ami_div u_div (
      .clk     (clk),
      .rst     (rst),
      .in_ctl  (dctl[j]),
      .num     (dnum[j]),
      .den     (RW'(dab)),
      .quo     (quo[j]),
      .quo_vld (quo_vld[j])
    );
  end

  tag_t sb [DIV_LAT];

  always_ff @(posedge clk) begin
    sb[0] <= '{row: irow, sing: sing_b, t: tsel};
    for (int k = 1; k < DIV_LAT; k++) begin
      sb[k] <= sb[k-1];
    end
  end

  // translation: accumulate t[row] * inverse row
  word_t      inv_m [3];
  prod_t      pa [3];
  word_t      rowa [3];
  logic [1:0] arow;
  logic       asing, va;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      inv_m[j] = sb[DIV_LAT-1].sing ? '0 : quo[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else begin
      va <= quo_vld[0];
    end
    for (int j = 0; j < 3; j++) begin
      pa[j] <= sb[DIV_LAT-1].t * inv_m[j];
    end
    rowa  <= inv_m;
    arow  <= sb[DIV_LAT-1].row;
    asing <= sb[DIV_LAT-1].sing;
  end

  acc_t       acc [3];
  word_t      rowb [3];
  logic [1:0] brow;
  logic       bsing, vb;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else begin
      vb <= va;
    end
    if (va) begin
      for (int j = 0; j < 3; j++) begin
        acc[j] <= (arow == 2'd0 ? acc_t'(0) : acc[j]) + acc_t'(pa[j]);
      end
    end
    rowb  <= rowa;
    brow  <= arow;
    bsing <= asing;
  end

  word_t trr [3];
  logic  tv, tsing;

  always_ff @(posedge clk) begin
    if (rst) begin
      tv <= 1'b0;
    end else begin
      tv <= vb && brow == 2'd2;
    end
    for (int j = 0; j < 3; j++) begin
      trr[j] <= bsing ? '0 : tr_sat(acc[j]);
    end
    tsing <= bsing;
  end

  // result port
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= vb || tv;
    end
    if (vb) begin
      row_index <= brow;
      col0      <= rowb[0];
      col1      <= rowb[1];
      col2      <= rowb[2];
      singular  <= bsing;
      last_row  <= 1'b0;
    end else begin
      row_index <= 2'd3;
      col0      <= trr[0];
      col1      <= trr[1];
      col2      <= trr[2];
      singular  <= tsing;
      last_row  <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after a word was taken");

  a_last_is_row3: assert property (@(posedge clk) disable iff (rst)
    strobe && last_row |-> row_index == 2'd3)
    else $error("last_row on a row other than the translation row");

  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    strobe && singular |-> col0 == '0 && col1 == '0 && col2 == '0)
    else $error("singular row carries nonzero data");

  a_rows_contiguous: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_row |=> strobe && row_index == $past(row_index) + 2'd1)
    else $error("result rows not back to back");
`endif

endmodule

`default_nettype wire

### tb/tb_affine_matrix_inverse.sv
// ----------------------------------------------------------------------------
// tb_affine_matrix_inverse
// checks the affine 3x4 inverse row by row against an exact-arithmetic
// predictor, over directed corner transforms and random ones, with the
// singular threshold moved through several settings on the register port
// ----------------------------------------------------------------------------
module tb_affine_matrix_inverse;
  timeunit 1ns;
  timeprecision 1ps;

  import ami_pkg::*;

  localparam int FB = 16;
  localparam int LAT = 60;
  localparam int WDOG = 2000;

  typedef struct packed {
    logic [1:0] ridx;
    word_t c0;
    word_t c1;
    word_t c2;
    logic sing;
    logic last;
  } row_t;

  typedef struct {
    word_t m [9];
    word_t t [3];
    logic has_row0;
    word_t row0 [3];
    logic sing;
  } dir_t;

  logic clk = 1'b0, rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  word_t mi [9];
  word_t ti [3];
  logic strobe;
  logic [1:0] row_index;
  word_t col0, col1, col2;
  logic singular, last_row;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  row_t rows_due [$];
  logic [15:0] thr_q;
  int errors = 0;
  int n_mats = 0, n_rows = 0, n_sing = 0;
  int idle_cycles = 0;
  logic timed_out = 1'b0;

  initial for (int i = 0; i < 9; i++) mi[i] = '0;
  initial for (int i = 0; i < 3; i++) ti[i] = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  affine_matrix_inverse dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .m00(mi[0]), .m01(mi[1]), .m02(mi[2]),
    .m10(mi[3]), .m11(mi[4]), .m12(mi[5]),
    .m20(mi[6]), .m21(mi[7]), .m22(mi[8]),
    .tx(ti[0]), .ty(ti[1]), .tz(ti[2]),
    .strobe(strobe), .row_index(row_index),
    .col0(col0), .col1(col1), .col2(col2),
    .singular(singular), .last_row(last_row),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  function automatic word_t sat32(logic signed [255:0] v);
    if (v > 256'sd2147483647) return 32'h7fffffff;
    if (v < -256'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic void predict_inverse(word_t m [9], word_t t [3]);
    logic signed [255:0] cf [9];
    logic signed [255:0] a [9];
    logic signed [255:0] det, adet, lim, s, q;
    word_t inv [9];
    word_t tr [3];
    logic sg;
    row_t r;
    for (int i = 0; i < 9; i++) a[i] = m[i];
    cf[0] = a[4]*a[8] - a[5]*a[7];
    cf[1] = a[2]*a[7] - a[1]*a[8];
    cf[2] = a[1]*a[5] - a[2]*a[4];
    cf[3] = a[5]*a[6] - a[3]*a[8];
    cf[4] = a[0]*a[8] - a[2]*a[6];
    cf[5] = a[2]*a[3] - a[0]*a[5];
    cf[6] = a[3]*a[7] - a[4]*a[6];
    cf[7] = a[1]*a[6] - a[0]*a[7];
    cf[8] = a[0]*a[4] - a[1]*a[3];
    det = a[0]*cf[0] + a[3]*cf[1] + a[6]*cf[2];
    adet = det < 0 ? -det : det;
    lim = $signed({240'd0, thr_q}) <<< (2*FB);
    sg = adet <= lim;
    for (int i = 0; i < 9; i++) begin
      if (sg) begin
        inv[i] = '0;
      end else begin
        q = (cf[i] <<< (2*FB)) / det;
        inv[i] = sat32(q);
      end
    end
    for (int j = 0; j < 3; j++) begin
      s = $signed(t[0])*$signed(inv[j]) + $signed(t[1])*$signed(inv[3+j])
        + $signed(t[2])*$signed(inv[6+j]);
      tr[j] = sg ? '0 : sat32((-s) >>> FB);
    end
    for (int k = 0; k < 4; k++) begin
      r.ridx = k[1:0];
      r.c0 = k < 3 ? inv[3*k] : tr[0];
      r.c1 = k < 3 ? inv[3*k+1] : tr[1];
      r.c2 = k < 3 ? inv[3*k+2] : tr[2];
      r.sing = sg;
      r.last = k == 3;
      rows_due.push_back(r);
    end
    if (sg) n_sing++;
  endfunction

  task automatic report_mismatch(string what, logic [127:0] got, logic [127:0] want);
    errors++;
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
  endtask

  always @(posedge clk) begin
    row_t e;
    if (!rst && strobe) begin
      n_rows++;
      if (rows_due.size() == 0) begin
        report_mismatch("unexpected word", row_index, 0);
      end else begin
        e = rows_due.pop_front();
        if (row_index !== e.ridx) report_mismatch("row_index", row_index, e.ridx);
        if (col0 !== e.c0) report_mismatch("col0", col0, e.c0);
        if (col1 !== e.c1) report_mismatch("col1", col1, e.c1);
        if (col2 !== e.c2) report_mismatch("col2", col2, e.c2);
        if (singular !== e.sing) report_mismatch("singular", singular, e.sing);
        if (last_row !== e.last) report_mismatch("last_row", last_row, e.last);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || strobe || (start && !busy) || (psel && penable)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WDOG) begin
      timed_out = 1'b1;
      $display("watchdog expired with %0d words pending", rows_due.size());
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_threshold(logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'(4*REG_THR); pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    thr_q = v[15:0];
    @(posedge clk);
    psel <= 1'b1; paddr <= 3'(4*REG_THR);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[15:0] !== thr_q) report_mismatch("threshold readback", prdata, thr_q);
    psel <= 1'b0; penable <= 1'b0;
  endtask

  task automatic drain();
    while (rows_due.size() != 0) @(posedge clk);
    repeat (LAT) @(posedge clk);
  endtask

  // issue one transform, holding start until taken
  task automatic send_matrix(word_t m [9], word_t t [3]);
    for (int i = 0; i < 9; i++) mi[i] <= m[i];
    for (int i = 0; i < 3; i++) ti[i] <= t[i];
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_inverse(m, t);
    n_mats++;
  endtask

  function automatic word_t rand_elem();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom();
      3: return 32'sd0;
      default: return 32'($signed($urandom_range(0, 8*65536)) - 4*65536);
    endcase
  endfunction

  task automatic run_random(int count);
    word_t m [9];
    word_t t [3];
    int burst;
    int gap;
    int k;
    k = 0;
    while (k < count) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst && k < count; b++) begin
        for (int i = 0; i < 9; i++) m[i] = rand_elem();
        for (int i = 0; i < 3; i++) t[i] = $urandom_range(0, 3) == 0 ? $urandom() : rand_elem();
        if ($urandom_range(0, 3) == 0) begin
          // each element of row 2 copies row 0 or twice row 1 (rank deficient when all picks match)
          for (int i = 0; i < 3; i++) m[6+i] = $urandom_range(0, 1) ? m[i] : m[3+i] <<< 1;
        end else if ($urandom_range(0, 2) == 0) begin
          // diagonal set to a whole number from 1 to 64
          for (int i = 0; i < 3; i++) m[4*i] = 32'($signed($urandom_range(1, 64)) << FB);
        end
        send_matrix(m, t);
        k++;
      end
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    start <= 1'b0;
  endtask

  dir_t dtab [$];

  function automatic dir_t mk(word_t d0, word_t d1, word_t d2, word_t o,
                              word_t tt, logic hr, word_t r0, logic sg);
    dir_t d;
    for (int i = 0; i < 9; i++) d.m[i] = o;
    d.m[0] = d0; d.m[4] = d1; d.m[8] = d2;
    for (int i = 0; i < 3; i++) d.t[i] = tt;
    d.has_row0 = hr;
    d.row0[0] = r0; d.row0[1] = '0; d.row0[2] = '0;
    d.sing = sg;
    return d;
  endfunction

  initial begin
    word_t m [9];
    word_t t [3];
    row_t e;
    thr_q = 16'd1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // identity, scaled, zero, extremes, singular, negative diagonal
    dtab.push_back(mk(32'h10000, 32'h10000, 32'h10000, '0, '0, 1, 32'h10000, 0));
    dtab.push_back(mk(32'h20000, 32'h20000, 32'h20000, '0, 32'h10000, 1, 32'h8000, 0));
    dtab.push_back(mk('0, '0, '0, '0, '0, 1, '0, 1));
    dtab.push_back(mk(32'h10000, 32'h10000, '0, '0, 32'h7fffffff, 1, '0, 1));
    dtab.push_back(mk(32'hffff0000, 32'h10000, 32'h10000, '0, 32'h80000000, 1,
                      32'hffff0000, 0));
    dtab.push_back(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, '0, 32'h7fffffff, 0, '0, 0));
    dtab.push_back(mk(32'h80000000, 32'h80000000, 32'h80000000, '0, 32'h80000000, 0, '0, 0));
    dtab.push_back(mk(32'h1, 32'h1, 32'h1, '0, 32'h10000, 1, '0, 1));
    dtab.push_back(mk(32'h100, 32'h100, 32'h100, '0, 32'h10000, 0, '0, 0));
    dtab.push_back(mk(32'h10000, 32'h10000, 32'h10000, 32'h10000, 32'h10000, 1, '0, 1));
    dtab.push_back(mk(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                      32'hffffffff, 0, '0, 0));
    dtab.push_back(mk(32'h30000, 32'h10000, 32'h20000, 32'h8000, 32'h12345678, 0, '0, 0));
    dtab.push_back(mk(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'h55555555,
                      32'haaaaaaaa, 0, '0, 0));

    foreach (dtab[k]) begin
      send_matrix(dtab[k].m, dtab[k].t);
      e = rows_due[rows_due.size()-4];
      if (dtab[k].has_row0 && (e.c0 !== dtab[k].row0[0] || e.sing !== dtab[k].sing))
        report_mismatch("directed table", e.c0, dtab[k].row0[0]);
    end
    start <= 1'b0;
    drain();

    // threshold at full scale, zero, one and a random value, random traffic at each
    write_threshold(32'h0000ffff);
    run_random(60);
    drain();
    write_threshold(32'h0);
    for (int i = 0; i < 9; i++) m[i] = '0;
    for (int i = 0; i < 3; i++) t[i] = '0;
    m[0] = 32'h1; m[4] = 32'h1; m[8] = 32'h1;
    send_matrix(m, t);
    run_random(100);
    drain();
    write_threshold(32'hffff0001);
    run_random(80);
    drain();
    write_threshold($urandom_range(0, 65535));
    run_random(100);
    drain();

    $display("covered %0d transforms, %0d result words, %0d singular", n_mats, n_rows, n_sing);
    $display("threshold swept over zero, one, full scale and random values");
    if (errors == 0 && !timed_out) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

### affine_matrix_inverse.f
hw/rtl/ami_pkg.sv
hw/rtl/ami_div.sv
hw/rtl/affine_matrix_inverse.sv
tb/tb_affine_matrix_inverse.sv
